// ===== rtl/dtar_pkg.sv =====
// Shared codes, register indexes and reset values for the trip and auto-reclose sequencer.
`default_nettype none

package dtar_pkg;

	// Operation codes carried by each input request.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_INJECT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_RESET  = 2'd3;

	// Reclose status codes.
	localparam logic [1:0] RC_READY    = 2'd0;
	localparam logic [1:0] RC_PROGRESS = 2'd1;
	localparam logic [1:0] RC_RECLOSED = 2'd2;
	localparam logic [1:0] RC_LOCKOUT  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_ZONE_ONE   = 3'd0;
	localparam logic [2:0] REG_ZONE_TWO   = 3'd1;
	localparam logic [2:0] REG_ZONE_THREE = 3'd2;
	localparam logic [2:0] REG_ZONE_FOUR  = 3'd3;
	localparam logic [2:0] REG_RECL_EN    = 3'd4;
	localparam logic [2:0] REG_RECL_LIMIT = 3'd5;
	localparam logic [2:0] REG_DEAD       = 3'd6;
	localparam logic [2:0] REG_RECLAIM    = 3'd7;

	// Configuration reset values.
	localparam logic [15:0] ZONE_ONE_RST    = 16'd0;
	localparam logic [15:0] ZONE_TWO_RST    = 16'd400;
	localparam logic [15:0] ZONE_THREE_RST  = 16'd800;
	localparam logic [15:0] ZONE_FOUR_RST   = 16'd1200;
	localparam logic        RECL_EN_RST     = 1'b1;
	localparam logic [3:0]  RECL_LIMIT_RST  = 4'd1;
	localparam logic [15:0] DEAD_RST        = 16'd1000;
	localparam logic [15:0] RECLAIM_RST     = 16'd5000;

	// Fixed timing and counting limits.
	localparam logic [15:0] PERSIST_MS  = 16'd100;
	localparam logic [3:0]  ATTEMPT_MAX = 4'd15;

	// Zone numbers.
	localparam logic [2:0] ZONE_NONE  = 3'd0;
	localparam logic [2:0] ZONE_ONE   = 3'd1;
	localparam logic [2:0] ZONE_TWO   = 3'd2;
	localparam logic [2:0] ZONE_THREE = 3'd3;
	localparam logic [2:0] ZONE_FOUR  = 3'd4;

	// Default width of the stored time stamp.
	localparam int TIME_BITS_DEF = 32;

endpackage

`default_nettype wire

// ===== rtl/distance_trip_autoreclose_sequencer.sv =====
// Distance-relay trip and auto-reclose sequencer: input stage, sequence logic, result register.
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+------------------------------------------
// input     | in        | in_valid / in_ready    | operation, fault_zone_in, time_now
// result    | out       | out_valid / out_ready  | seq_state, trip_out, operate_zone,
//           |           |                        | reclose_status, accepted, fault_flag,
//           |           |                        | attempts_used
// config    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Every input request passes through the input register, then through the sequence logic
// into the result register. One request is accepted per cycle while the result is not
// stalled; the sequence state is read and written in the same cycle as the result
// register is loaded.
// Reset (arst_n low) returns the sequence to idle and the configuration to its defaults.
// A stalled result holds the result register and then the input register; a new request
// is taken whenever the input register is empty or moves on in the same cycle.

module distance_trip_autoreclose_sequencer
	import dtar_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [2:0]  fault_zone_in,
	input  wire logic [31:0] time_now,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       seq_state,
	output logic             trip_out,
	output logic [2:0]       operate_zone,
	output logic [1:0]       reclose_status,
	output logic             accepted,
	output logic             fault_flag,
	output logic [3:0]       attempts_used,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// Sequence phases; the code doubles as the reported state.
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_STARTED  = 3'd1,
		PH_TRIPPED  = 3'd2,
		PH_DEAD     = 3'd3,
		PH_SYNC     = 3'd4,
		PH_RECLOSED = 3'd5,
		PH_LOCKOUT  = 3'd6
	} phase_t;

	// Configuration registers. The user must write them only while the block is idle, so
	// that no request in flight sees a change; the block itself does not enforce this.
	logic [15:0] zone_one_q, zone_two_q, zone_three_q, zone_four_q;
	logic        recl_en_q;
	logic [3:0]  recl_limit_q;
	logic [15:0] dead_q, reclaim_q;

	// Input register stage.
	logic           valid_s1;
	logic [1:0]     op_s1;
	logic [2:0]     zone_s1;
	logic [31:0]    time_s1;

	// Sequence state.
	phase_t                 phase_q;
	logic [2:0]             zone_held_q;
	logic                   fault_q;
	logic [TIME_BITS-1:0]   entry_time_q;
	logic [3:0]             attempt_q;
	logic                   trip_q;
	logic [1:0]             recl_code_q;

	// Result register.
	logic        out_valid_q;
	logic        accepted_q;

	// Next-state values computed from the request in the input stage.
	phase_t                 phase_d;
	logic [2:0]             zone_held_d;
	logic                   fault_d;
	logic [TIME_BITS-1:0]   entry_time_d;
	logic [3:0]             attempt_d;
	logic                   trip_d;
	logic [1:0]             recl_code_d;
	logic                   accepted_d;

	logic                   advance;
	logic [TIME_BITS-1:0]   now_w;
	logic [TIME_BITS-1:0]   elapsed;
	logic [15:0]            trip_delay;
	logic [2:0]             zone_norm;

	// The request in the input stage moves on when the result register is free or is
	// being emptied in this cycle.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// The time stamp is kept modulo 2^TIME_BITS, so elapsed time is a plain wrapping
	// difference compared as an unsigned number.
	assign now_w   = TIME_BITS'(time_s1);
	assign elapsed = now_w - entry_time_q;

	// Trip delay of the zone held; a zone outside 1..4 takes the zone two delay.
	always_comb begin
		case (zone_held_q)
			ZONE_ONE:   trip_delay = zone_one_q;
			ZONE_TWO:   trip_delay = zone_two_q;
			ZONE_THREE: trip_delay = zone_three_q;
			ZONE_FOUR:  trip_delay = zone_four_q;
			default:    trip_delay = zone_two_q;
		endcase
	end

	// An injected zone outside 1..4 is taken as zone one.
	assign zone_norm = ((zone_s1 >= ZONE_ONE) && (zone_s1 <= ZONE_FOUR)) ? zone_s1 : ZONE_ONE;

	// Sequence transitions for one request.
	always_comb begin
		phase_d      = phase_q;
		zone_held_d  = zone_held_q;
		fault_d      = fault_q;
		entry_time_d = entry_time_q;
		attempt_d    = attempt_q;
		trip_d       = trip_q;
		recl_code_d  = recl_code_q;
		accepted_d   = 1'b1;
		case (op_s1)
			OP_TICK: begin
				case (phase_q)
					PH_STARTED: begin
						// Pickup: trip once the zone delay has run out.
						if (elapsed >= TIME_BITS'(trip_delay)) begin
							trip_d       = 1'b1;
							phase_d      = PH_TRIPPED;
							entry_time_d = now_w;
						end
					end
					PH_TRIPPED: begin
						// Start a reclose attempt if allowed, otherwise lock out.
						if (recl_en_q && (attempt_q < recl_limit_q)) begin
							phase_d      = PH_DEAD;
							entry_time_d = now_w;
							recl_code_d  = RC_PROGRESS;
						end else begin
							phase_d = PH_LOCKOUT;
						end
					end
					PH_DEAD: begin
						if (elapsed >= TIME_BITS'(dead_q)) begin
							phase_d      = PH_SYNC;
							entry_time_d = now_w;
						end
					end
					PH_SYNC: begin
						// The synchronism check passes at once and the breaker recloses.
						if (attempt_q != ATTEMPT_MAX) begin
							attempt_d = attempt_q + 4'd1;
						end
						phase_d      = PH_RECLOSED;
						entry_time_d = now_w;
						recl_code_d  = RC_RECLOSED;
					end
					PH_RECLOSED: begin
						if (fault_q && (elapsed >= TIME_BITS'(PERSIST_MS))) begin
							// Fault persists after reclosing: final trip.
							trip_d       = 1'b1;
							phase_d      = PH_LOCKOUT;
							entry_time_d = now_w;
							recl_code_d  = RC_LOCKOUT;
						end else if (!fault_q && (elapsed >= TIME_BITS'(reclaim_q))) begin
							// Reclaim time passed without a fault: sequence complete.
							trip_d      = 1'b0;
							recl_code_d = RC_READY;
							phase_d     = PH_IDLE;
							attempt_d   = 4'd0;
						end
					end
					default: begin
					end
				endcase
			end
			OP_INJECT: begin
				if (phase_q != PH_IDLE) begin
					accepted_d = 1'b0;
				end else begin
					fault_d      = 1'b1;
					zone_held_d  = zone_norm;
					phase_d      = PH_STARTED;
					entry_time_d = now_w;
					attempt_d    = 4'd0;
				end
			end
			OP_CLEAR: begin
				fault_d = 1'b0;
			end
			default: begin
				// Full reset keeps only the time stamp.
				fault_d     = 1'b0;
				phase_d     = PH_IDLE;
				zone_held_d = ZONE_NONE;
				attempt_d   = 4'd0;
				trip_d      = 1'b0;
				recl_code_d = RC_READY;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_one_q   <= ZONE_ONE_RST;
			zone_two_q   <= ZONE_TWO_RST;
			zone_three_q <= ZONE_THREE_RST;
			zone_four_q  <= ZONE_FOUR_RST;
			recl_en_q    <= RECL_EN_RST;
			recl_limit_q <= RECL_LIMIT_RST;
			dead_q       <= DEAD_RST;
			reclaim_q    <= RECLAIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ZONE_ONE:   zone_one_q   <= cfg_data;
				REG_ZONE_TWO:   zone_two_q   <= cfg_data;
				REG_ZONE_THREE: zone_three_q <= cfg_data;
				REG_ZONE_FOUR:  zone_four_q  <= cfg_data;
				REG_RECL_EN:    recl_en_q    <= cfg_data[0];
				REG_RECL_LIMIT: recl_limit_q <= cfg_data[3:0];
				REG_DEAD:       dead_q       <= cfg_data;
				REG_RECLAIM:    reclaim_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register: control bit under reset, payload loaded on acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			zone_s1 <= fault_zone_in;
			time_s1 <= time_now;
		end
	end

	// Sequence state, result valid and the accepted flag of the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			zone_held_q  <= ZONE_NONE;
			fault_q      <= 1'b0;
			entry_time_q <= '0;
			attempt_q    <= 4'd0;
			trip_q       <= 1'b0;
			recl_code_q  <= RC_READY;
			out_valid_q  <= 1'b0;
			accepted_q   <= 1'b0;
		end else begin
			if (advance) begin
				phase_q      <= phase_d;
				zone_held_q  <= zone_held_d;
				fault_q      <= fault_d;
				entry_time_q <= entry_time_d;
				attempt_q    <= attempt_d;
				trip_q       <= trip_d;
				recl_code_q  <= recl_code_d;
				out_valid_q  <= 1'b1;
				accepted_q   <= accepted_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The state registers double as the result register: they change only when a new
	// result is loaded.
	assign out_valid      = out_valid_q;
	assign seq_state      = phase_q;
	assign trip_out       = trip_q;
	assign operate_zone   = zone_held_q;
	assign reclose_status = recl_code_q;
	assign accepted       = accepted_q;
	assign fault_flag     = fault_q;
	assign attempts_used  = attempt_q;

	// Idle always means the trip is released and reclose is ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (!trip_q && (recl_code_q == RC_READY)))
	else $error("idle phase with trip or reclose status left set");

	// Reclosed is only entered through the sync check, which counts an attempt.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RECLOSED) |-> (attempt_q != 4'd0))
	else $error("reclosed phase with no attempt counted");

	// The sequence state moves only with a request leaving the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(phase_q) && $stable(entry_time_q) && $stable(attempt_q)))
	else $error("sequence state changed without a request");

	// A result being held must not be overwritten by the next request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
	else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== sim/tb_distance_trip_autoreclose_sequencer.sv =====
// Self-checking testbench for the distance trip and auto-reclose sequencer.
`timescale 1ns / 1ps

module tb_distance_trip_autoreclose_sequencer;
	import dtar_pkg::*;

	// Sequence state codes as they appear on seq_state.
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_STARTED  = 3'd1;
	localparam logic [2:0] PH_TRIPPED  = 3'd2;
	localparam logic [2:0] PH_DEAD     = 3'd3;
	localparam logic [2:0] PH_SYNC     = 3'd4;
	localparam logic [2:0] PH_RECLOSED = 3'd5;
	localparam logic [2:0] PH_LOCKOUT  = 3'd6;

	// Each side skips a cycle in about this many of a hundred.
	localparam int IDLE_PCT      = 6;
	// Result counts that bound the stretch in which neither side idles.
	localparam int CALM_FROM     = 700;
	localparam int CALM_TO       = 900;
	// The receiver holds off once for this many cycles after HOLD_AT results.
	localparam int HOLD_AT       = 150;
	localparam int HOLD_CYCLES   = 80;
	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT   = 2000;
	// Random requests per settings phase.
	localparam int PHASE_ITEMS   = 255;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  zone;
		logic [31:0] stamp;
	} relay_request_t;

	typedef struct packed {
		logic [2:0] seq_state;
		logic       trip_out;
		logic [2:0] operate_zone;
		logic [1:0] reclose_status;
		logic       accepted;
		logic       fault_flag;
		logic [3:0] attempts_used;
	} relay_status_t;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_TICK;
	logic [2:0]  fault_zone_in = ZONE_NONE;
	logic [31:0] time_now = 32'd0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  seq_state;
	logic        trip_out;
	logic [2:0]  operate_zone;
	logic [1:0]  reclose_status;
	logic        accepted;
	logic        fault_flag;
	logic [3:0]  attempts_used;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_ZONE_ONE;
	logic [15:0] cfg_data = 16'd0;

	distance_trip_autoreclose_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.fault_zone_in(fault_zone_in),
		.time_now(time_now),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.seq_state(seq_state),
		.trip_out(trip_out),
		.operate_zone(operate_zone),
		.reclose_status(reclose_status),
		.accepted(accepted),
		.fault_flag(fault_flag),
		.attempts_used(attempts_used),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Requests waiting for the driver, and the status each accepted request should produce.
	relay_request_t queued_requests [$];
	relay_status_t  awaited_status [$];
	relay_request_t next_req;

	// Shadow of the configuration registers, updated when a write is accepted.
	logic [15:0] zone_dly [0:3] = '{ZONE_ONE_RST, ZONE_TWO_RST, ZONE_THREE_RST, ZONE_FOUR_RST};
	logic        recl_en    = RECL_EN_RST;
	logic [3:0]  recl_limit = RECL_LIMIT_RST;
	logic [15:0] dead_ms    = DEAD_RST;
	logic [15:0] reclaim_len = RECLAIM_RST;
	logic [15:0] setting_plan [0:7];

	// Our own copy of the sequence state; everything clears at reset.
	logic [2:0]  seq_phase    = PH_IDLE;
	logic [2:0]  held_zone    = ZONE_NONE;
	logic        fault_on     = 1'b0;
	logic [31:0] stamp        = 32'd0;
	logic [3:0]  attempt_cnt  = 4'd0;
	logic        trip_latched = 1'b0;
	logic [1:0]  rc_code      = RC_READY;

	logic [31:0] clock_ms;
	logic        in_fire = 1'b0;
	logic        hold_done = 1'b0;
	logic [7:0]  phases_seen = 8'd0;
	int          hold_left = 0;
	int          items_made = 0;
	int          in_count = 0;
	int          out_count = 0;
	int          cfg_writes = 0;
	int          settings_used = 1;
	int          mismatches = 0;
	int          stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advances the shadow sequence by one request and returns the status the block should
	// report for it. Elapsed time is a plain 32-bit subtraction, so wrap-around is modular.
	function automatic relay_status_t relay_response(input logic [1:0] op,
			input logic [2:0] zin, input logic [31:0] now);
		logic [31:0]   elapsed;
		logic [15:0]   dly;
		logic          ok;
		relay_status_t res;
		elapsed = now - stamp;
		ok = 1'b1;
		case (op)
			OP_TICK: begin
				case (seq_phase)
					PH_STARTED: begin
						// A held zone outside one to four falls back to the zone two delay.
						case (held_zone)
							ZONE_ONE:   dly = zone_dly[0];
							ZONE_THREE: dly = zone_dly[2];
							ZONE_FOUR:  dly = zone_dly[3];
							default:    dly = zone_dly[1];
						endcase
						if (elapsed >= {16'd0, dly}) begin
							trip_latched = 1'b1;
							seq_phase = PH_TRIPPED;
							stamp = now;
						end
					end
					PH_TRIPPED: begin
						if (recl_en && attempt_cnt < recl_limit) begin
							seq_phase = PH_DEAD;
							stamp = now;
							rc_code = RC_PROGRESS;
						end else begin
							seq_phase = PH_LOCKOUT;
						end
					end
					PH_DEAD: begin
						if (elapsed >= {16'd0, dead_ms}) begin
							seq_phase = PH_SYNC;
							stamp = now;
						end
					end
					PH_SYNC: begin
						// The sync check always passes on the first tick.
						if (attempt_cnt < ATTEMPT_MAX)
							attempt_cnt = attempt_cnt + 4'd1;
						seq_phase = PH_RECLOSED;
						stamp = now;
						rc_code = RC_RECLOSED;
					end
					PH_RECLOSED: begin
						if (fault_on && elapsed >= {16'd0, PERSIST_MS}) begin
							trip_latched = 1'b1;
							seq_phase = PH_LOCKOUT;
							stamp = now;
							rc_code = RC_LOCKOUT;
						end else if (!fault_on && elapsed >= {16'd0, reclaim_len}) begin
							// Reclaim done: the zone stays on display.
							trip_latched = 1'b0;
							rc_code = RC_READY;
							seq_phase = PH_IDLE;
							attempt_cnt = 4'd0;
						end
					end
					default: begin
					end
				endcase
			end
			OP_INJECT: begin
				if (seq_phase != PH_IDLE) begin
					ok = 1'b0;
				end else begin
					fault_on = 1'b1;
					held_zone = (zin >= ZONE_ONE && zin <= ZONE_FOUR) ? zin : ZONE_ONE;
					seq_phase = PH_STARTED;
					stamp = now;
					attempt_cnt = 4'd0;
				end
			end
			OP_CLEAR: begin
				fault_on = 1'b0;
			end
			default: begin
				// Full reset keeps only the time stamp.
				fault_on = 1'b0;
				seq_phase = PH_IDLE;
				held_zone = ZONE_NONE;
				attempt_cnt = 4'd0;
				trip_latched = 1'b0;
				rc_code = RC_READY;
			end
		endcase
		res.seq_state = seq_phase;
		res.trip_out = trip_latched;
		res.operate_zone = held_zone;
		res.reclose_status = rc_code;
		res.accepted = ok;
		res.fault_flag = fault_on;
		res.attempts_used = attempt_cnt;
		return res;
	endfunction

	// Picks a time step that often lands on, just before or just after a configured interval,
	// so that the boundaries of every timer get hit. Now and then it jumps far ahead.
	function automatic logic [31:0] next_gap();
		logic [31:0] base;
		int          pick;
		pick = $urandom_range(0, 5);
		if (pick < 4)
			base = {16'd0, zone_dly[pick]};
		else if (pick == 4)
			base = {16'd0, dead_ms};
		else
			base = {16'd0, reclaim_len};
		case ($urandom_range(0, 11))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return {16'd0, PERSIST_MS} - 32'd1;
			3:       return {16'd0, PERSIST_MS};
			4, 5:    return base;
			6:       return base - 32'd1;
			7:       return base + 32'd1;
			8, 9:    return $urandom_range(0, base / 3 + 1);
			10:      return $urandom_range(0, 255);
			default: return ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000);
		endcase
	endfunction

	task automatic push_request(input logic [1:0] op, input logic [2:0] zone,
			input logic [31:0] t);
		queued_requests.push_back('{op, zone, t});
		items_made++;
	endtask

	// A well-formed fault sequence: inject, then a run of ticks that walks the block through
	// pickup, trip, dead time, reclose and then reclaim or lockout. Some sequences clear the
	// fault along the way, some throw in a refused inject, and half end in a full reset.
	task automatic queue_sequence();
		int n;
		int r;
		int clear_pct;
		if ($urandom_range(0, 9) == 0)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		push_request(OP_INJECT, 3'($urandom_range(0, 7)), clock_ms);
		clear_pct = ($urandom_range(0, 1) == 1) ? 0 : 12;
		n = $urandom_range(4, 14);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < clear_pct) begin
				push_request(OP_CLEAR, 3'($urandom_range(0, 7)), clock_ms);
			end else if (r < clear_pct + 4) begin
				push_request(OP_INJECT, 3'($urandom_range(0, 7)), clock_ms);
			end else begin
				clock_ms = clock_ms + next_gap();
				push_request(OP_TICK, 3'($urandom_range(0, 7)), clock_ms);
			end
		end
		if ($urandom_range(0, 1) == 1)
			push_request(OP_RESET, 3'($urandom_range(0, 7)), clock_ms);
	endtask

	// Mostly sequences, the rest fully random requests with arbitrary time stamps.
	task automatic queue_random(input int count);
		int target;
		target = items_made + count;
		while (items_made < target) begin
			if ($urandom_range(0, 99) < 80) begin
				queue_sequence();
			end else begin
				repeat ($urandom_range(1, 4))
					push_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom());
			end
		end
	endtask

	// Waits until every queued request has been sent and answered.
	task automatic settle();
		while (queued_requests.size() != 0 || in_valid || awaited_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(input logic [2:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_ZONE_ONE:   zone_dly[0] = data;
			REG_ZONE_TWO:   zone_dly[1] = data;
			REG_ZONE_THREE: zone_dly[2] = data;
			REG_ZONE_FOUR:  zone_dly[3] = data;
			REG_RECL_EN:    recl_en = data[0];
			REG_RECL_LIMIT: recl_limit = data[3:0];
			REG_DEAD:       dead_ms = data;
			default:        reclaim_len = data;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drains the block, loads every register from setting_plan and queues a random batch.
	task automatic run_phase();
		settle();
		for (int i = REG_ZONE_ONE; i <= REG_RECLAIM; i++)
			write_setting(3'(i), setting_plan[i]);
		settings_used++;
		queue_random(PHASE_ITEMS);
	endtask

	// Records the outcome of each input handshake and predicts the status it will produce.
	always @(posedge clk) begin
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			awaited_status.push_back(relay_response(operation, fault_zone_in, time_now));
			in_count++;
		end
	end

	// Driver: offers the next queued request on the falling edge once the previous one has
	// gone, skipping a cycle now and then except inside the calm stretch.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (queued_requests.size() != 0 &&
					((in_count >= CALM_FROM && in_count < CALM_TO) ||
					$urandom_range(0, 99) >= IDLE_PCT)) begin
				next_req = queued_requests.pop_front();
				in_valid <= 1'b1;
				operation <= next_req.op;
				fault_zone_in <= next_req.zone;
				time_now <= next_req.stamp;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off that fills the pipeline and stalls
	// the input side, and a calm stretch where every result is taken at once.
	always @(negedge clk) begin
		if (!hold_done && out_count >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (out_count >= CALM_FROM && out_count < CALM_TO) ||
				($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s at result %0d: expected %0d, got %0d",
					fname, out_count, want, got);
		end
	endtask

	// Monitor: each result taken is compared, field by field, with the oldest prediction.
	always @(posedge clk) begin
		relay_status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with no request outstanding", out_count);
			end else begin
				want = awaited_status.pop_front();
				check_field("seq_state", want.seq_state, seq_state);
				check_field("trip_out", want.trip_out, trip_out);
				check_field("operate_zone", want.operate_zone, operate_zone);
				check_field("reclose_status", want.reclose_status, reclose_status);
				check_field("accepted", want.accepted, accepted);
				check_field("fault_flag", want.fault_flag, fault_flag);
				check_field("attempts_used", want.attempts_used, attempts_used);
			end
			phases_seen[seq_state] = 1'b1;
			out_count++;
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d results still outstanding",
					STALL_LIMIT, awaited_status.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		clock_ms = $urandom();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed walk with the reset settings (zone one trips at once, one reclose allowed).
		push_request(OP_TICK, ZONE_NONE, 32'd1000);          // tick while idle does nothing
		push_request(OP_INJECT, ZONE_NONE, 32'd1000);        // zone zero falls back to zone one
		push_request(OP_INJECT, ZONE_TWO, 32'd1000);         // refused, sequence already running
		push_request(OP_TICK, ZONE_NONE, 32'd1000);          // zero delay trips immediately
		push_request(OP_TICK, ZONE_NONE, 32'd1005);          // into dead time
		push_request(OP_TICK, ZONE_NONE, 32'd2004);          // one short of the dead time
		push_request(OP_TICK, ZONE_NONE, 32'd2005);          // dead time over, sync check
		push_request(OP_TICK, ZONE_NONE, 32'd2005);          // sync passes, reclosed
		push_request(OP_TICK, ZONE_NONE, 32'd2104);          // fault still there, not yet
		push_request(OP_TICK, ZONE_NONE, 32'd2105);          // persisting fault, lockout
		push_request(OP_TICK, ZONE_NONE, 32'd9000);          // lockout holds
		push_request(OP_CLEAR, ZONE_NONE, 32'd9000);
		push_request(OP_RESET, ZONE_NONE, 32'd9000);
		// Zone four across the 32-bit wrap of the millisecond counter.
		push_request(OP_INJECT, ZONE_FOUR, 32'hFFFF_FF00);
		push_request(OP_TICK, 3'd7, 32'hFFFF_FF00 + 32'd1199);
		push_request(OP_TICK, ZONE_NONE, 32'hFFFF_FF00 + 32'd1200);
		push_request(OP_TICK, ZONE_NONE, 32'd1000);
		push_request(OP_CLEAR, ZONE_NONE, 32'd1000);
		push_request(OP_TICK, ZONE_NONE, 32'd2000);
		push_request(OP_TICK, ZONE_NONE, 32'd2000);
		push_request(OP_TICK, ZONE_NONE, 32'd6999);          // reclaim one short
		push_request(OP_TICK, ZONE_NONE, 32'd7000);          // reclaim done, back to idle
		push_request(OP_INJECT, 3'd5, 32'd7000);             // zone five falls back to zone one
		push_request(OP_TICK, ZONE_NONE, 32'd100);           // time going backwards still trips
		push_request(OP_RESET, 3'd7, 32'hFFFF_FFFF);

		// Short intervals, reclose on, random limit with noise in the unused data bits.
		for (int i = REG_ZONE_ONE; i <= REG_ZONE_FOUR; i++)
			setting_plan[i] = 16'($urandom_range(0, 150));
		setting_plan[REG_RECL_EN] = {15'($urandom()), 1'b1};
		setting_plan[REG_RECL_LIMIT] = {12'($urandom()), 4'($urandom_range(1, 15))};
		setting_plan[REG_DEAD] = 16'($urandom_range(0, 300));
		setting_plan[REG_RECLAIM] = 16'($urandom_range(0, 300));
		run_phase();

		// Everything at zero: no delays, reclose disabled, no attempts allowed.
		for (int i = REG_ZONE_ONE; i <= REG_RECLAIM; i++)
			setting_plan[i] = 16'h0000;
		run_phase();

		// Everything at its maximum.
		for (int i = REG_ZONE_ONE; i <= REG_RECLAIM; i++)
			setting_plan[i] = 16'hFFFF;
		run_phase();

		// Fully random values in every register.
		for (int i = REG_ZONE_ONE; i <= REG_RECLAIM; i++)
			setting_plan[i] = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 500))
				: 16'($urandom());
		setting_plan[REG_RECL_EN] = 16'($urandom());
		setting_plan[REG_RECL_LIMIT] = 16'($urandom());
		run_phase();

		// Reclose enabled but the limit at zero, so every trip goes straight to lockout.
		for (int i = REG_ZONE_ONE; i <= REG_RECLAIM; i++)
			setting_plan[i] = 16'($urandom_range(0, 200));
		setting_plan[REG_RECL_EN] = 16'h0001;
		setting_plan[REG_RECL_LIMIT] = 16'h0000;
		run_phase();

		// Let the last results drain, then keep the clock running so that any extra result shows.
		while (queued_requests.size() != 0 || in_valid || awaited_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests, checked %0d results under %0d register settings (%0d writes).",
			in_count, out_count, settings_used, cfg_writes);
		$display("Sequence states reported (bit per state): %b, mismatches %0d, left over %0d.",
			phases_seen, mismatches, awaited_status.size());
		if (mismatches == 0 && awaited_status.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
